[src/lcdbs_pkg.sv]
// Shared types and constants of the LCD byte-stream unit.
`default_nettype none

package lcdbs_pkg;

  // Input request modes.
  localparam logic [1:0] MODE_WINDOW = 2'd0;
  localparam logic [1:0] MODE_GLYPH  = 2'd1;
  localparam logic [1:0] MODE_RAW    = 2'd2;

  // Controller commands.
  localparam logic [7:0] CMD_COL_ADDR = 8'h2A;
  localparam logic [7:0] CMD_ROW_ADDR = 8'h2B;
  localparam logic [7:0] CMD_MEM_WR   = 8'h2C;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_TEXT_COLOR = 3'd0;
  localparam logic [2:0] REG_BG_COLOR   = 3'd1;
  localparam logic [2:0] REG_LSB_FIRST  = 3'd2;
  localparam logic [2:0] REG_X_OFFSET   = 3'd3;
  localparam logic [2:0] REG_Y_OFFSET   = 3'd4;

  localparam int unsigned PADDR_W = 5;

  // Final step of each request kind.
  localparam logic [3:0] WINDOW_LAST_STEP = 4'd10;
  localparam logic [3:0] GLYPH_LAST_STEP  = 4'd15;
  localparam logic [3:0] RAW_LAST_STEP    = 4'd0;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    KIND_WINDOW = 2'd0,
    KIND_GLYPH  = 2'd1,
    KIND_RAW    = 2'd2
  } kind_e;

  typedef struct packed {
    logic [15:0] text_color;
    logic [15:0] background_color;
    logic        lsb_first;
    logic [7:0]  x_offset;
    logic [7:0]  y_offset;
  } cfg_t;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] col_start;
    logic [15:0] col_end;
    logic [15:0] row_start;
    logic [15:0] row_end;
    logic [7:0]  pixels;
  } desc_t;

endpackage

`default_nettype wire

[src/lcdbs_front.sv]
// Front end: classifies requests and works out the window addresses.
`default_nettype none

module lcdbs_front import lcdbs_pkg::*; (
  input  wire logic        accept_i,
  input  wire logic [1:0]  mode_i,
  input  wire logic [9:0]  start_x_i,
  input  wire logic [9:0]  start_y_i,
  input  wire logic [10:0] width_i,
  input  wire logic [10:0] height_i,
  input  wire logic [7:0]  bitmap_byte_i,
  input  wire cfg_t        cfg_i,
  output logic             push_o,
  output desc_t            desc_o
);

  logic [15:0] col_s;
  logic [15:0] row_s;

  // Addresses are 16-bit and wrap, so a zero size gives start minus one.
  assign col_s = {6'd0, start_x_i} + {8'd0, cfg_i.x_offset};
  assign row_s = {6'd0, start_y_i} + {8'd0, cfg_i.y_offset};

  always_comb begin
    desc_o.col_start = col_s;
    desc_o.col_end   = col_s + {5'd0, width_i} - 16'd1;
    desc_o.row_start = row_s;
    desc_o.row_end   = row_s + {5'd0, height_i} - 16'd1;
    desc_o.pixels    = bitmap_byte_i;
    desc_o.kind      = KIND_WINDOW;
    push_o           = 1'b0;
    case (mode_i)
      MODE_WINDOW: begin
        desc_o.kind = KIND_WINDOW;
        push_o      = accept_i;
      end
      MODE_GLYPH: begin
        desc_o.kind = KIND_GLYPH;
        push_o      = accept_i;
      end
      MODE_RAW: begin
        desc_o.kind = KIND_RAW;
        push_o      = accept_i;
      end
      default: begin
        push_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

[src/lcdbs_queue.sv]
// Small request queue between the front end and the byte sequencer.
`default_nettype none

module lcdbs_queue import lcdbs_pkg::*; #(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire desc_t desc_i,
  input  wire logic  pop_i,
  output desc_t      head_o,
  output logic       empty_o,
  output logic       full_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  desc_t         mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CntFull);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= desc_i;
    end
  end

endmodule

`default_nettype wire

[src/lcdbs_back.sv]
// Back end: steps through each request and emits one byte per cycle.
`default_nettype none

module lcdbs_back import lcdbs_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire cfg_t  cfg_i,
  input  wire desc_t head_i,
  input  wire logic  empty_i,
  output logic       pop_o,
  output logic       strobe_o,
  output logic [7:0] out_byte_o,
  output logic       is_data_o,
  output logic       last_o
);

  desc_t      cur_q;
  logic       active_q;
  logic [3:0] step_q;
  logic [3:0] last_step;
  logic       done;
  logic [7:0] byte_d;
  logic       data_d;
  logic [2:0] pix_idx;
  logic [2:0] bit_pos;
  logic [15:0] color;

  assign pix_idx = step_q[3:1];
  assign bit_pos = cfg_i.lsb_first ? pix_idx : ~pix_idx;
  assign color   = cur_q.pixels[bit_pos] ? cfg_i.text_color : cfg_i.background_color;

  always_comb begin
    byte_d    = 8'd0;
    data_d    = 1'b1;
    last_step = RAW_LAST_STEP;
    case (cur_q.kind)
      KIND_WINDOW: begin
        last_step = WINDOW_LAST_STEP;
        case (step_q)
          4'd0:    begin byte_d = CMD_COL_ADDR; data_d = 1'b0; end
          4'd1:    byte_d = cur_q.col_start[15:8];
          4'd2:    byte_d = cur_q.col_start[7:0];
          4'd3:    byte_d = cur_q.col_end[15:8];
          4'd4:    byte_d = cur_q.col_end[7:0];
          4'd5:    begin byte_d = CMD_ROW_ADDR; data_d = 1'b0; end
          4'd6:    byte_d = cur_q.row_start[15:8];
          4'd7:    byte_d = cur_q.row_start[7:0];
          4'd8:    byte_d = cur_q.row_end[15:8];
          4'd9:    byte_d = cur_q.row_end[7:0];
          default: begin byte_d = CMD_MEM_WR; data_d = 1'b0; end
        endcase
      end
      KIND_GLYPH: begin
        last_step = GLYPH_LAST_STEP;
        byte_d    = step_q[0] ? color[7:0] : color[15:8];
      end
      default: begin
        last_step = RAW_LAST_STEP;
        byte_d    = cur_q.pixels;
      end
    endcase
  end

  assign done  = active_q && (step_q == last_step);
  assign pop_o = (!active_q || done) && !empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      step_q   <= '0;
      strobe_o <= 1'b0;
    end else begin
      strobe_o <= active_q;
      if (!active_q || done) begin
        active_q <= !empty_i;
        step_q   <= '0;
      end else begin
        step_q <= step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= head_i;
    end
    out_byte_o <= byte_d;
    is_data_o  <= data_d;
    last_o     <= done;
  end

endmodule

`default_nettype wire

[src/glyph_to_lcd_byte_stream_unit.sv]
// Top level of the LCD byte-stream unit: registers, front end, queue, sequencer.
//
//   Channel     Signals                                   Direction  Handshake
//   request     start_i, mode_i, start_x_i, start_y_i,    in         start_i high, busy_o low
//               width_i, height_i, bitmap_byte_i
//   byte out    strobe_o, out_byte_o, is_data_o, last_o   out        strobe_o, one cycle
//   config      psel, penable, pwrite, paddr, pwdata,     in/out     APB, pready always high
//               prdata, pready
//
// A window request yields eleven bytes, a glyph request sixteen and a raw request one,
// at one byte per clock from a single sequencer, so that sequencer sets the sustained
// rate. An accepted request passes through the queue and the sequencer's request
// register before its first byte is registered out; back-to-back requests follow each
// other with no gap. Requests wait in a queue of QueueDepth entries, and busy_o is high
// while that queue is full. Mode 3 requests are accepted and dropped. The receiver
// cannot stall the byte stream. Reset is asynchronous and restores the register defaults
// (white text on black, MSB first, zero offsets).
`default_nettype none

module glyph_to_lcd_byte_stream_unit import lcdbs_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Drawing requests.
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic [1:0]         mode_i,
  input  wire logic [9:0]         start_x_i,
  input  wire logic [9:0]         start_y_i,
  input  wire logic [10:0]        width_i,
  input  wire logic [10:0]        height_i,
  input  wire logic [7:0]         bitmap_byte_i,
  // Byte stream to the display controller.
  output logic                    strobe_o,
  output logic [7:0]              out_byte_o,
  output logic                    is_data_o,
  output logic                    last_o,
  // Configuration port.
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  cfg_t       cfg_q;
  logic [2:0] reg_idx;
  logic       cfg_wr;
  logic       accept;
  logic       push;
  desc_t      front_desc;
  desc_t      head;
  logic       pop;
  logic       q_empty;
  logic       q_full;

  // Register file. Writes land in the access phase; reads return the stored value.
  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.text_color       <= 16'hFFFF;
      cfg_q.background_color <= 16'h0000;
      cfg_q.lsb_first        <= 1'b0;
      cfg_q.x_offset         <= 8'd0;
      cfg_q.y_offset         <= 8'd0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_TEXT_COLOR: cfg_q.text_color       <= pwdata[15:0];
        REG_BG_COLOR:   cfg_q.background_color <= pwdata[15:0];
        REG_LSB_FIRST:  cfg_q.lsb_first        <= pwdata[0];
        REG_X_OFFSET:   cfg_q.x_offset         <= pwdata[7:0];
        REG_Y_OFFSET:   cfg_q.y_offset         <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_TEXT_COLOR: prdata = {16'd0, cfg_q.text_color};
      REG_BG_COLOR:   prdata = {16'd0, cfg_q.background_color};
      REG_LSB_FIRST:  prdata = {31'd0, cfg_q.lsb_first};
      REG_X_OFFSET:   prdata = {24'd0, cfg_q.x_offset};
      REG_Y_OFFSET:   prdata = {24'd0, cfg_q.y_offset};
      default:        prdata = 32'd0;
    endcase
  end

  // A request is taken whenever the queue has room.
  assign busy_o = q_full;
  assign accept = start_i && !busy_o;

  lcdbs_front u_front (
    .accept_i      (accept),
    .mode_i        (mode_i),
    .start_x_i     (start_x_i),
    .start_y_i     (start_y_i),
    .width_i       (width_i),
    .height_i      (height_i),
    .bitmap_byte_i (bitmap_byte_i),
    .cfg_i         (cfg_q),
    .push_o        (push),
    .desc_o        (front_desc)
  );

  lcdbs_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .desc_i  (front_desc),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  // Colors and bit order are read live; change them only while idle (not enforced).
  lcdbs_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .head_i     (head),
    .empty_i    (q_empty),
    .pop_o      (pop),
    .strobe_o   (strobe_o),
    .out_byte_o (out_byte_o),
    .is_data_o  (is_data_o),
    .last_o     (last_o)
  );

endmodule

`default_nettype wire

[verif/glyph_to_lcd_byte_stream_checker.sv]
// Checker for the LCD byte-stream unit: predicts each request's bytes and compares them.
module glyph_to_lcd_byte_stream_checker import lcdbs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic [1:0]         mode_i,
  input  logic [9:0]         start_x_i,
  input  logic [9:0]         start_y_i,
  input  logic [10:0]        width_i,
  input  logic [10:0]        height_i,
  input  logic [7:0]         bitmap_byte_i,
  input  logic               strobe_i,
  input  logic [7:0]         out_byte_i,
  input  logic               is_data_i,
  input  logic               last_i,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic [PADDR_W-1:0] paddr_i,
  input  logic [31:0]        pwdata_i,
  input  logic               pready_i,
  output int                 mismatch_count_o,
  output int                 outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] value;
    logic       is_data;
    logic       last;
  } lcd_byte_t;

  cfg_t      panel_cfg;
  lcd_byte_t expected_bytes[$];

  initial begin
    mismatch_count_o = 0;
    outstanding_o    = 0;
  end

  task automatic report_mismatch(input string what);
    mismatch_count_o++;
    $display("%0t ns: byte stream mismatch: %s", $time, what);
  endtask

  task automatic queue_byte(input logic [7:0] value, input logic is_data);
    lcd_byte_t entry;
    entry.value   = value;
    entry.is_data = is_data;
    entry.last    = 1'b0;
    expected_bytes.push_back(entry);
  endtask

  // Address command followed by start and end, high byte first; end wraps modulo 2^16.
  task automatic queue_address_range(input logic [7:0] command, input logic [15:0] first,
                                     input logic [10:0] size);
    logic [15:0] final_addr;
    final_addr = first + {5'd0, size} - 16'd1;
    queue_byte(command, 1'b0);
    queue_byte(first[15:8], 1'b1);
    queue_byte(first[7:0], 1'b1);
    queue_byte(final_addr[15:8], 1'b1);
    queue_byte(final_addr[7:0], 1'b1);
  endtask

  task automatic predict_request(input logic [1:0] mode, input logic [9:0] start_x,
                                 input logic [9:0] start_y, input logic [10:0] width,
                                 input logic [10:0] height, input logic [7:0] bitmap);
    logic [15:0] color;
    int          depth;
    int          i;
    int          pos;
    depth = expected_bytes.size();
    case (mode)
      MODE_WINDOW: begin
        queue_address_range(CMD_COL_ADDR, {6'd0, start_x} + {8'd0, panel_cfg.x_offset}, width);
        queue_address_range(CMD_ROW_ADDR, {6'd0, start_y} + {8'd0, panel_cfg.y_offset}, height);
        queue_byte(CMD_MEM_WR, 1'b0);
      end
      MODE_GLYPH: begin
        for (i = 0; i < 8; i++) begin
          pos   = panel_cfg.lsb_first ? i : 7 - i;
          color = bitmap[pos] ? panel_cfg.text_color : panel_cfg.background_color;
          queue_byte(color[15:8], 1'b1);
          queue_byte(color[7:0], 1'b1);
        end
      end
      MODE_RAW: begin
        queue_byte(bitmap, 1'b1);
      end
      default: begin
        // The unused mode is dropped without output.
      end
    endcase
    if (expected_bytes.size() > depth) begin
      expected_bytes[expected_bytes.size() - 1].last = 1'b1;
    end
  endtask

  task automatic check_byte();
    lcd_byte_t want;
    if (expected_bytes.size() == 0) begin
      report_mismatch($sformatf("byte %02h with nothing expected", out_byte_i));
    end else begin
      want = expected_bytes.pop_front();
      if (out_byte_i !== want.value) begin
        report_mismatch($sformatf("out_byte %02h, want %02h", out_byte_i, want.value));
      end
      if (is_data_i !== want.is_data) begin
        report_mismatch($sformatf("is_data %b, want %b (byte %02h)",
                                  is_data_i, want.is_data, want.value));
      end
      if (last_i !== want.last) begin
        report_mismatch($sformatf("last %b, want %b (byte %02h)",
                                  last_i, want.last, want.value));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      panel_cfg.text_color       = 16'hFFFF;
      panel_cfg.background_color = 16'h0000;
      panel_cfg.lsb_first        = 1'b0;
      panel_cfg.x_offset         = 8'h00;
      panel_cfg.y_offset         = 8'h00;
      expected_bytes.delete();
    end else begin
      // A request accepted at this edge cannot produce a byte at the same edge.
      if (strobe_i) begin
        check_byte();
      end
      if (start_i && !busy_i) begin
        predict_request(mode_i, start_x_i, start_y_i, width_i, height_i, bitmap_byte_i);
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[PADDR_W-1:2])
          REG_TEXT_COLOR: panel_cfg.text_color       = pwdata_i[15:0];
          REG_BG_COLOR:   panel_cfg.background_color = pwdata_i[15:0];
          REG_LSB_FIRST:  panel_cfg.lsb_first        = pwdata_i[0];
          REG_X_OFFSET:   panel_cfg.x_offset         = pwdata_i[7:0];
          REG_Y_OFFSET:   panel_cfg.y_offset         = pwdata_i[7:0];
          default: begin
            // Writes to unused addresses change nothing.
          end
        endcase
      end
    end
    outstanding_o = expected_bytes.size();
  end

endmodule

[verif/tb_glyph_to_lcd_byte_stream_unit.sv]
// Testbench top for the LCD byte-stream unit: clock, reset, stimulus and verdict.
module tb_glyph_to_lcd_byte_stream_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import lcdbs_pkg::*;

  // Free-running 100 MHz clock.
  logic clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic [1:0]         mode_i;
  logic [9:0]         start_x_i;
  logic [9:0]         start_y_i;
  logic [10:0]        width_i;
  logic [10:0]        height_i;
  logic [7:0]         bitmap_byte_i;
  logic               strobe_o;
  logic [7:0]         out_byte_o;
  logic               is_data_o;
  logic               last_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  // Bytes still owed by the block, and the number of mismatches seen so far.
  int outstanding_bytes;
  int mismatches;

  glyph_to_lcd_byte_stream_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .mode_i        (mode_i),
    .start_x_i     (start_x_i),
    .start_y_i     (start_y_i),
    .width_i       (width_i),
    .height_i      (height_i),
    .bitmap_byte_i (bitmap_byte_i),
    .strobe_o      (strobe_o),
    .out_byte_o    (out_byte_o),
    .is_data_o     (is_data_o),
    .last_o        (last_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // The checker sees the block's pins apart from prdata and does all of the prediction.
  glyph_to_lcd_byte_stream_checker stream_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_i           (busy_o),
    .mode_i           (mode_i),
    .start_x_i        (start_x_i),
    .start_y_i        (start_y_i),
    .width_i          (width_i),
    .height_i         (height_i),
    .bitmap_byte_i    (bitmap_byte_i),
    .strobe_i         (strobe_o),
    .out_byte_i       (out_byte_o),
    .is_data_i        (is_data_o),
    .last_i           (last_o),
    .psel_i           (psel),
    .penable_i        (penable),
    .pwrite_i         (pwrite),
    .paddr_i          (paddr),
    .pwdata_i         (pwdata),
    .pready_i         (pready),
    .mismatch_count_o (mismatches),
    .outstanding_o    (outstanding_bytes)
  );

  // Presents one request after an optional idle gap and holds it until the block takes it.
  // All pins change at the falling edge; busy_o is read at the rising edge, where it
  // still holds the value that decides acceptance. The task returns at the falling
  // edge after acceptance with start_i still high, so a request that follows with no
  // gap keeps start_i high and only the payload changes.
  task automatic send_request(input logic [1:0] mode, input logic [9:0] start_x,
                              input logic [9:0] start_y, input logic [10:0] width,
                              input logic [10:0] height, input logic [7:0] bitmap,
                              input int unsigned gap);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    mode_i        <= mode;
    start_x_i     <= start_x;
    start_y_i     <= start_y;
    width_i       <= width;
    height_i      <= height;
    bitmap_byte_i <= bitmap;
    start_i       <= 1'b1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Stops requesting until every predicted byte has come out, then keeps waiting so the
  // sequencer is surely idle; a request's first byte only shows up once it has passed
  // the queue and the sequencer's registers.
  task automatic wait_drained();
    start_i <= 1'b0;
    while (outstanding_bytes != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // One APB write: a setup phase, then an access phase that ends when pready is seen.
  // An idle phase follows, so back-to-back writes never touch psel twice in one step.
  task automatic write_register(input logic [2:0] index, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  // Loads all five registers; upper bits beyond a register's width are don't-care.
  task automatic set_panel(input logic [31:0] text, input logic [31:0] background,
                           input logic [31:0] lsb, input logic [31:0] x_off,
                           input logic [31:0] y_off);
    write_register(REG_TEXT_COLOR, text);
    write_register(REG_BG_COLOR, background);
    write_register(REG_LSB_FIRST, lsb);
    write_register(REG_X_OFFSET, x_off);
    write_register(REG_Y_OFFSET, y_off);
  endtask

  initial begin
    int unsigned gap;
    int unsigned pick;
    int unsigned counted;
    int unsigned issued;
    int          phase;
    logic [1:0]  mode;
    logic [9:0]  start_x;
    logic [9:0]  start_y;
    logic [10:0] width;
    logic [10:0] height;
    logic [7:0]  bitmap;

    // Every input starts at a known value, with reset asserted.
    rst_ni        = 1'b0;
    start_i       = 1'b0;
    mode_i        = MODE_WINDOW;
    start_x_i     = '0;
    start_y_i     = '0;
    width_i       = '0;
    height_i      = '0;
    bitmap_byte_i = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed requests with the reset colors: white on black, MSB first, no offsets.
    // Windows at the smallest and largest legal sizes, then a zero size (the end
    // address wraps below the start) and sizes beyond the legal range.
    send_request(MODE_WINDOW, 10'd0, 10'd0, 11'd1, 11'd1, 8'h00, $urandom_range(0, 6));
    send_request(MODE_WINDOW, 10'd1023, 10'd1023, 11'd1024, 11'd1024, 8'h00,
                 $urandom_range(0, 6));
    send_request(MODE_WINDOW, 10'd0, 10'd0, 11'd0, 11'd0, 8'h00, $urandom_range(0, 6));
    send_request(MODE_WINDOW, 10'd1023, 10'd0, 11'd2047, 11'd2047, 8'hFF, 0);
    // Glyph bytes: all clear, all set, and a lone bit at either end. Unused fields
    // carry zeros or junk that the block must ignore.
    send_request(MODE_GLYPH, 10'd0, 10'd0, 11'd0, 11'd0, 8'h00, 0);
    send_request(MODE_GLYPH, 10'd0, 10'd0, 11'd0, 11'd0, 8'hFF, 0);
    send_request(MODE_GLYPH, 10'd0, 10'd0, 11'd0, 11'd0, 8'h80, $urandom_range(0, 6));
    send_request(MODE_GLYPH, 10'd1023, 10'd1023, 11'd2047, 11'd2047, 8'h01, 0);
    send_request(MODE_RAW, 10'd0, 10'd0, 11'd0, 11'd0, 8'h00, 0);
    send_request(MODE_RAW, 10'd0, 10'd0, 11'd0, 11'd0, 8'hFF, 0);
    send_request(MODE_RAW, 10'd1023, 10'd1023, 11'd2047, 11'd2047, 8'hA5, 0);
    // The unused mode is accepted and yields nothing.
    send_request(2'd3, 10'd1023, 10'd1023, 11'd2047, 11'd2047, 8'hFF, 0);
    send_request(2'd3, 10'd0, 10'd0, 11'd0, 11'd0, 8'h00, $urandom_range(0, 6));
    send_request(MODE_GLYPH, 10'd0, 10'd0, 11'd0, 11'd0, 8'h5A, 0);

    // Flip every register to its other extreme, with garbage in some upper bits.
    wait_drained();
    set_panel(32'hFFFF_0000, 32'h0000_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_00FF);
    send_request(MODE_GLYPH, 10'd0, 10'd0, 11'd0, 11'd0, 8'h80, 0);
    send_request(MODE_GLYPH, 10'd0, 10'd0, 11'd0, 11'd0, 8'h01, 0);
    send_request(MODE_GLYPH, 10'd0, 10'd0, 11'd0, 11'd0, 8'hC3, $urandom_range(0, 6));
    // Largest start plus largest offset, and a zero size at the offset itself.
    send_request(MODE_WINDOW, 10'd1023, 10'd1023, 11'd1024, 11'd1024, 8'h00, 0);
    send_request(MODE_WINDOW, 10'd0, 10'd0, 11'd0, 11'd0, 8'h00, 0);
    send_request(MODE_RAW, 10'd0, 10'd0, 11'd0, 11'd0, 8'h3C, 0);
    send_request(2'd3, 10'd5, 10'd5, 11'd5, 11'd5, 8'h55, 0);
    send_request(MODE_WINDOW, 10'd512, 10'd1, 11'd2047, 11'd0, 8'h00, $urandom_range(0, 6));

    // Random phases. Each starts from an idle block with a fresh register setting:
    // the first two pin the remaining extremes, the rest are fully random.
    for (phase = 0; phase < 6; phase++) begin
      wait_drained();
      case (phase)
        0: begin
          // A write to an address past the last register must change nothing.
          write_register(3'd5, $urandom());
          set_panel(32'h0, 32'h0, 32'h0, 32'h0, 32'hFF);
        end
        1: set_panel(32'hFFFF, 32'hFFFF, 32'h1, 32'hFF, 32'h0);
        default: set_panel($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
      endcase

      counted = 0;
      issued  = 0;
      while (counted < 71) begin
        // Unused fields always carry random junk.
        start_x = 10'($urandom());
        start_y = 10'($urandom());
        width   = 11'($urandom());
        height  = 11'($urandom());
        bitmap  = 8'($urandom());
        pick    = $urandom_range(0, 19);
        if (pick < 5) begin
          mode = MODE_WINDOW;
          // Mostly legal sizes, now and then any value the field can hold.
          if ($urandom_range(0, 9) != 0) begin
            width  = 11'($urandom_range(1, 1024));
            height = 11'($urandom_range(1, 1024));
          end
        end else if (pick < 12) begin
          mode = MODE_GLYPH;
        end else if (pick < 19) begin
          mode = MODE_RAW;
        end else begin
          mode = 2'd3;
        end

        // Stretches of back-to-back requests alternate with random idle gaps.
        gap = ((issued / 12) % 3 == 0) ? 0 : $urandom_range(0, 6);
        send_request(mode, start_x, start_y, width, height, bitmap, gap);
        issued++;
        if (mode != 2'd3) begin
          counted++;
        end

        // In phase 2, once mid-phase, let the block run completely dry before going on.
        if (phase == 2 && counted == 30 && mode != 2'd3) begin
          wait_drained();
        end
      end
    end

    // Drain the last bytes, then watch a while longer for any stray strobe.
    wait_drained();
    repeat (16) @(negedge clk_i);
    if (mismatches == 0 && outstanding_bytes == 0) begin
      $display("tb_glyph_to_lcd_byte_stream_unit OK");
    end else begin
      $display("tb_glyph_to_lcd_byte_stream_unit NOT OK");
    end
    $finish;
  end

  // Watchdog: a correct run takes well under a tenth of this.
  initial begin
    #2_000_000;
    $display("tb_glyph_to_lcd_byte_stream_unit NOT OK");
    $finish;
  end

endmodule

[filelist.f]
src/lcdbs_pkg.sv
src/lcdbs_front.sv
src/lcdbs_queue.sv
src/lcdbs_back.sv
src/glyph_to_lcd_byte_stream_unit.sv
verif/glyph_to_lcd_byte_stream_checker.sv
verif/tb_glyph_to_lcd_byte_stream_unit.sv
